>>> hw/rtl/cmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types and constants of the coverage mask compositor.
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 13;
  localparam int OFFSET_W  = 9;
  localparam int PIXEL_W   = 8;

  localparam logic [CFG_W-1:0]   CANVAS_SIZE_RESET = 9'd256;
  localparam logic [PIXEL_W-1:0] COV_FULL          = 8'd255;
  localparam logic [16:0]        ROUND_BIAS        = 17'd127;

  typedef enum logic [1:0] {
    REQ_BLEND = 2'd0,
    REQ_READ  = 2'd1,
    REQ_ZERO  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_WIDTH  = 1'b0,
    CFG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC
  } back_state_t;

endpackage

>>> hw/rtl/cmc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmc_ram #(
  parameter int WIDTH = cmc_pkg::PIXEL_W,
  parameter int DEPTH = cmc_pkg::DEF_MAX_WIDTH * cmc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/cmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_queue
// Short FIFO between the front and back units, head shown combinationally.
// ----------------------------------------------------------------------------
module cmc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cmc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/cmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_front
// Holds the canvas size registers, takes requests, works out the target
// pixel, its bounds check and store address, and queues the classified item.
// ----------------------------------------------------------------------------
module cmc_front #(
  parameter int MAX_WIDTH  = cmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cmc_pkg::DEF_MAX_HEIGHT,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cmc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic signed [cmc_pkg::COORD_W-1:0]  origin_x,
  input  logic signed [cmc_pkg::COORD_W-1:0]  origin_y,
  input  logic [cmc_pkg::OFFSET_W-1:0]        offset_col,
  input  logic [cmc_pkg::OFFSET_W-1:0]        offset_row,
  input  logic [cmc_pkg::PIXEL_W-1:0]         pixel_coverage,
  input  logic                                back_busy,
  input  logic                                q_full,
  output logic                                push,
  output logic [AW+10:0]                      push_data
);
  import cmc_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  typedef struct packed {
    req_t             kind;
    logic             in_canvas;
    logic [7:0]       cov;
    logic [AW-1:0]    addr;
  } entry_t;

  logic [CFG_W-1:0] canvas_width;
  logic [CFG_W-1:0] canvas_height;
  req_t             kind;
  logic [13:0]      tx;
  logic [13:0]      ty;
  logic [12:0]      w_lim;
  logic [12:0]      h_lim;
  logic             in_x;
  logic             in_y;
  entry_t           entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_SIZE_RESET;
      canvas_height <= CANVAS_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        CFG_CANVAS_HEIGHT: canvas_height <= cfg_data;
      endcase
    end
  end

  always_comb begin
    kind  = req_t'(req_type);
    w_lim = (13'(canvas_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(canvas_width);
    h_lim = (13'(canvas_height) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(canvas_height);
    if (kind == REQ_BLEND) begin
      tx = {origin_x[12], origin_x} + {5'd0, offset_col};
      ty = {origin_y[12], origin_y} + {5'd0, offset_row};
    end else begin
      tx = {origin_x[12], origin_x};
      ty = {origin_y[12], origin_y};
    end
    in_x = !tx[13] && (tx[12:0] < w_lim);
    in_y = !ty[13] && (ty[12:0] < h_lim);

    entry.kind      = kind;
    entry.in_canvas = in_x && in_y;
    entry.cov       = pixel_coverage;
    entry.addr      = AW'(AW'(ty[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(tx[XW-1:0]);
  end

  assign in_ready  = !q_full && !back_busy;
  assign push      = in_valid && in_ready;
  assign push_data = entry;

endmodule

>>> hw/rtl/cmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_back
// Clears the canvas after reset, then runs queued items against the canvas
// store: read, blend arithmetic, write back, and the output register.
// ----------------------------------------------------------------------------
module cmc_back #(
  parameter int MAX_WIDTH  = cmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cmc_pkg::DEF_MAX_HEIGHT,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [AW+10:0]              q_head,
  output logic                        q_pop,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cmc_pkg::PIXEL_W-1:0] pixel_value,
  output logic                        clipped_flag,
  output logic                        out_of_range
);
  import cmc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    req_t             kind;
    logic             in_canvas;
    logic [7:0]       cov;
    logic [AW-1:0]    addr;
  } entry_t;

  back_state_t   state;
  back_state_t   state_next;
  entry_t        head;
  entry_t        cur;
  logic [AW-1:0] clr_cnt;
  logic [7:0]    d_reg;
  logic [15:0]   prod;
  logic          clipped_sticky;
  logic          clipped_sticky_next;
  logic          slot_free;
  logic          load;
  logic          head_reads;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    ram_rdata;
  logic [7:0]    res_value;
  logic          res_oor;
  logic [16:0]   biased;
  logic [8:0]    q0;
  logic [16:0]   rem;
  logic [8:0]    quo;
  logic [7:0]    blended;

  assign head       = entry_t'(q_head);
  assign head_reads = head.in_canvas && (head.kind == REQ_BLEND || head.kind == REQ_READ);
  assign slot_free  = !out_valid || out_ready;
  assign busy       = (state == ST_CLEAR);

  cmc_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (head.addr),
    .rdata (ram_rdata)
  );

  // divide by 255: estimate, then one correction step
  always_comb begin
    biased  = 17'(prod) + ROUND_BIAS;
    q0      = 9'((biased + (biased >> 8)) >> 8);
    rem     = biased - ({q0, 8'd0} - 17'(q0));
    quo     = (rem >= 17'd255) ? q0 + 9'd1 : q0;
    blended = 8'(9'(cur.cov) + quo);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (!q_empty) state_next = head_reads ? ST_READ : ST_CALC;
      ST_READ:  state_next = ST_CALC;
      ST_CALC:  if (slot_free) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop               = 1'b0;
    load                = 1'b0;
    wr_en               = 1'b0;
    wr_addr             = cur.addr;
    wr_data             = '0;
    res_value           = '0;
    res_oor             = 1'b0;
    clipped_sticky_next = clipped_sticky;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
      end
      ST_IDLE: begin
        q_pop = !q_empty;
      end
      ST_READ: begin
      end
      ST_CALC: begin
        load = slot_free;
        unique case (cur.kind)
          REQ_BLEND: begin
            if (!cur.in_canvas) begin
              res_oor = 1'b1;
              if (cur.cov != '0) clipped_sticky_next = 1'b1;
            end else if (cur.cov == '0) begin
              res_value = d_reg;
            end else begin
              res_value = blended;
              wr_data   = blended;
              wr_en     = slot_free;
            end
          end
          REQ_READ: begin
            if (cur.in_canvas) res_value = d_reg;
            else res_oor = 1'b1;
          end
          REQ_ZERO: begin
            if (cur.in_canvas) wr_en = slot_free;
            else res_oor = 1'b1;
          end
          REQ_CLEAR: begin
            clipped_sticky_next = 1'b0;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_cnt        <= '0;
      clipped_sticky <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (load) begin
        clipped_sticky <= clipped_sticky_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    if (state == ST_READ) begin
      d_reg <= ram_rdata;
      prod  <= 16'(16'(ram_rdata) * 16'(COV_FULL - cur.cov));
    end
    if (load) begin
      pixel_value  <= res_value;
      clipped_flag <= clipped_sticky_next;
      out_of_range <= res_oor;
    end
  end

endmodule

>>> hw/rtl/coverage_mask_compositor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_mask_compositor_unit
// Composites 8-bit glyph coverage into an 8-bit canvas store, with pixel
// read, pixel zero and a sticky clipped flag.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | transfer when
//  ---------+------------------------------------------------+--------------------
//  request  | req_type origin_x origin_y offset_col/row cov  | in_valid & in_ready
//  result   | pixel_value clipped_flag out_of_range          | out_valid & out_ready
//  config   | cfg_index cfg_data                             | cfg_we
//
// after reset the canvas is swept to zero, one pixel a cycle, through all
// MAX_WIDTH*MAX_HEIGHT pixels; no request is taken then.
// a blend or read inside the canvas goes through the idle, read and calc states
// of the back unit (store read, multiply, divide and write back), every other
// request through idle and calc only; calc holds until the output slot is free.
// a two-entry queue lets the front take requests while the back works, and the
// output register lets the back start the next item while a result waits.
// ----------------------------------------------------------------------------
module coverage_mask_compositor_unit #(
  parameter int MAX_WIDTH  = cmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cmc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cmc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic signed [cmc_pkg::COORD_W-1:0]  origin_x,
  input  logic signed [cmc_pkg::COORD_W-1:0]  origin_y,
  input  logic [cmc_pkg::OFFSET_W-1:0]        offset_col,
  input  logic [cmc_pkg::OFFSET_W-1:0]        offset_row,
  input  logic [cmc_pkg::PIXEL_W-1:0]         pixel_coverage,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cmc_pkg::PIXEL_W-1:0]         pixel_value,
  output logic                                clipped_flag,
  output logic                                out_of_range
);
  import cmc_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int ENTRY_W = AW + 11;

  logic               back_busy;
  logic               q_full;
  logic               q_empty;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] q_head;

  cmc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .offset_col     (offset_col),
    .offset_row     (offset_row),
    .pixel_coverage (pixel_coverage),
    .back_busy      (back_busy),
    .q_full         (q_full),
    .push           (push),
    .push_data      (push_data)
  );

  cmc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  cmc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (pop),
    .busy         (back_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_value  (pixel_value),
    .clipped_flag (clipped_flag),
    .out_of_range (out_of_range)
  );

endmodule
